/* hdl/lbdh_pkg.sv */
// lbdh_pkg: shared widths, operation codes and store entry layouts for the
// log bucket duration histogram. No dependencies.
`default_nettype none

package lbdh_pkg;

    // field widths of the item and result ports
    localparam int OP_W    = 1;
    localparam int CAT_W   = 3;
    localparam int DUR_W   = 48;
    localparam int BKT_W   = 4;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 64;

    // bucket threshold register: one bit above the duration so that a
    // saturated threshold exceeds every duration
    localparam int THR_W   = DUR_W + 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_RECORD = 1'b0;
    localparam logic [OP_W-1:0] OP_READ   = 1'b1;

    // one bucket entry of the histogram store
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [DUR_W-1:0] min_ns;
        logic [DUR_W-1:0] max_ns;
    } bkt_entry_t;

    // one category entry of the totals store
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum_ns;
    } cat_entry_t;

endpackage

`default_nettype wire

/* hdl/lbdh_ram.sv */
// lbdh_ram: generic single write port, single read port RAM with a
// registered read. No dependencies.
`default_nettype none

module lbdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/log_bucket_duration_histogram.sv */
// log_bucket_duration_histogram: top level of the duration statistics engine.
// Depends on lbdh_pkg and lbdh_ram.
`default_nettype none

// Usage
//   Command channel: an item (operation, category, duration_ns, read_bucket)
//   is taken at a rising edge with start high and busy low. A record item
//   adds the duration to its category and to one logarithmic bucket; a read
//   item returns one bucket and its category.
//   Result channel: every item gives one result, shown for one cycle with
//   done high. The receiver cannot stall it; it must take the result then.
//   Sequence: a record walks the bucket thresholds with one shared
//   shift-and-compare step per cycle, one step per bucket passed plus a
//   final step that ends the walk, then a store read and an update. A read
//   skips the walk and goes straight to the store read and the update.
//   Throughput: one item at a time; busy is low again in the cycle that
//   done is shown, so the next item may be taken then.
//   Reset: the store is cleared by a sweep over all CATEGORIES * BUCKETS
//   bucket entries, one bucket entry per cycle, while busy stays high.
//   Counts and the category total saturate at their maximum.
module log_bucket_duration_histogram
    import lbdh_pkg::*;
#(
    parameter int CATEGORIES      = 6,
    parameter int BUCKETS         = 10,
    parameter int BUCKET_SHIFT    = 2,
    parameter int FIRST_BUCKET_NS = 62500
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [OP_W-1:0]  operation,
    input  wire logic [CAT_W-1:0] category,
    input  wire logic [DUR_W-1:0] duration_ns,
    input  wire logic [BKT_W-1:0] read_bucket,
    output logic                  done,
    output logic [BKT_W-1:0]      bucket_index,
    output logic [CNT_W-1:0]      bucket_samples,
    output logic [DUR_W-1:0]      bucket_min_ns,
    output logic [DUR_W-1:0]      bucket_max_ns,
    output logic [CNT_W-1:0]      category_samples,
    output logic [SUM_W-1:0]      category_total_ns
);

    localparam int BDEPTH = CATEGORIES * BUCKETS;
    localparam int BAW    = $clog2(BDEPTH);
    localparam int CAW    = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
    localparam int SHW    = THR_W + BUCKET_SHIFT;

    localparam logic [BKT_W-1:0] LAST_BKT  = BKT_W'(BUCKETS - 1);
    localparam logic [THR_W-1:0] THR_FIRST = THR_W'(FIRST_BUCKET_NS);
    localparam logic [THR_W-1:0] THR_SAT   = {1'b1, {(THR_W-1){1'b0}}};
    localparam logic [BAW-1:0]   CLR_LAST  = BAW'(BDEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    state_t            state_reg, state_next;
    logic [BAW-1:0]    clr_reg, clr_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [CAT_W-1:0]  cat_reg, cat_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [BKT_W-1:0]  bucket_reg, bucket_next;
    logic [THR_W-1:0]  thr_reg, thr_next;

    logic              done_reg, done_next;
    logic [BKT_W-1:0]  bucket_index_reg, bucket_index_next;
    logic [CNT_W-1:0]  bucket_samples_reg, bucket_samples_next;
    logic [DUR_W-1:0]  bucket_min_reg, bucket_min_next;
    logic [DUR_W-1:0]  bucket_max_reg, bucket_max_next;
    logic [CNT_W-1:0]  cat_samples_reg, cat_samples_next;
    logic [SUM_W-1:0]  cat_total_reg, cat_total_next;

    // store ports
    logic              bkt_we, cat_we;
    logic [BAW-1:0]    bkt_waddr, bkt_addr;
    logic [CAW-1:0]    cat_waddr, cat_addr;
    bkt_entry_t        bkt_wdata, bkt_rd, bkt_new;
    cat_entry_t        cat_wdata, cat_rd, cat_new;
    logic [$bits(bkt_entry_t)-1:0] bkt_rdata;
    logic [$bits(cat_entry_t)-1:0] cat_rdata;

    // datapath helpers
    logic              cat_ok, bkt_ok, bkt_empty;
    logic [SHW-1:0]    thr_shifted;
    logic [SUM_W:0]    sum_wide;

    lbdh_ram #(
        .WIDTH ($bits(bkt_entry_t)),
        .DEPTH (BDEPTH)
    ) u_bkt_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bkt_addr),
        .rdata (bkt_rdata)
    );

    lbdh_ram #(
        .WIDTH ($bits(cat_entry_t)),
        .DEPTH (CATEGORIES)
    ) u_cat_ram (
        .clk   (clk),
        .we    (cat_we),
        .waddr (cat_waddr),
        .wdata (cat_wdata),
        .raddr (cat_addr),
        .rdata (cat_rdata)
    );

    assign bkt_rd = bkt_entry_t'(bkt_rdata);
    assign cat_rd = cat_entry_t'(cat_rdata);

    // range checks and store addresses of the current item
    always_comb
    begin
        cat_ok   = (int'(cat_reg) < CATEGORIES);
        bkt_ok   = (int'(bucket_reg) < BUCKETS);
        bkt_addr = (cat_ok && bkt_ok)
                   ? BAW'(int'(cat_reg) * BUCKETS + int'(bucket_reg)) : '0;
        cat_addr = cat_ok ? CAW'(cat_reg) : '0;
    end

    // shared threshold step: threshold moved up by the shift, widened so
    // that an overflow past the duration range can be seen
    always_comb
    begin
        thr_shifted = SHW'(thr_reg) << BUCKET_SHIFT;
    end

    // bucket and category update from the stored entries
    always_comb
    begin
        bkt_empty      = (bkt_rd.cnt == '0);
        bkt_new.cnt    = (&bkt_rd.cnt) ? bkt_rd.cnt : bkt_rd.cnt + CNT_W'(1);
        bkt_new.min_ns = (bkt_empty || (dur_reg < bkt_rd.min_ns)) ? dur_reg : bkt_rd.min_ns;
        bkt_new.max_ns = (bkt_empty || (dur_reg > bkt_rd.max_ns)) ? dur_reg : bkt_rd.max_ns;
        sum_wide       = {1'b0, cat_rd.sum_ns} + (SUM_W + 1)'(dur_reg);
        cat_new.sum_ns = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        cat_new.cnt    = (&cat_rd.cnt) ? cat_rd.cnt : cat_rd.cnt + CNT_W'(1);
    end

    // sequencer
    always_comb
    begin
        state_next          = state_reg;
        clr_next            = clr_reg;
        op_next             = op_reg;
        cat_next            = cat_reg;
        dur_next            = dur_reg;
        bucket_next         = bucket_reg;
        thr_next            = thr_reg;
        done_next           = 1'b0;
        bucket_index_next   = bucket_index_reg;
        bucket_samples_next = bucket_samples_reg;
        bucket_min_next     = bucket_min_reg;
        bucket_max_next     = bucket_max_reg;
        cat_samples_next    = cat_samples_reg;
        cat_total_next      = cat_total_reg;
        bkt_we              = 1'b0;
        cat_we              = 1'b0;
        bkt_waddr           = bkt_addr;
        cat_waddr           = cat_addr;
        bkt_wdata           = bkt_new;
        cat_wdata           = cat_new;

        case (state_reg)
            ST_CLEAR:
            begin
                // zero one bucket entry per cycle, category entries alongside
                bkt_we    = 1'b1;
                bkt_waddr = clr_reg;
                bkt_wdata = '0;
                cat_we    = (int'(clr_reg) < CATEGORIES);
                cat_waddr = CAW'(clr_reg);
                cat_wdata = '0;
                clr_next  = clr_reg + BAW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next  = operation;
                    cat_next = category;
                    dur_next = duration_ns;
                    thr_next = THR_FIRST;
                    if (operation == OP_RECORD)
                    begin
                        bucket_next = '0;
                        state_next  = ST_SEARCH;
                    end
                    else
                    begin
                        bucket_next = read_bucket;
                        state_next  = ST_LOOKUP;
                    end
                end
            end
            ST_SEARCH:
            begin
                // one threshold compare per cycle; thresholds grow by the shift
                if ((bucket_reg != LAST_BKT) && (THR_W'(dur_reg) >= thr_reg))
                begin
                    bucket_next = bucket_reg + BKT_W'(1);
                    thr_next    = (thr_shifted[SHW-1:THR_W-1] != '0)
                                  ? THR_SAT : thr_shifted[THR_W-1:0];
                end
                else
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // store addresses are presented; data returns next cycle
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                bucket_index_next   = bucket_reg;
                bucket_samples_next = '0;
                bucket_min_next     = '0;
                bucket_max_next     = '0;
                cat_samples_next    = '0;
                cat_total_next      = '0;
                if (cat_ok)
                begin
                    if (op_reg == OP_RECORD)
                    begin
                        bkt_we              = 1'b1;
                        cat_we              = 1'b1;
                        bucket_samples_next = bkt_new.cnt;
                        bucket_min_next     = bkt_new.min_ns;
                        bucket_max_next     = bkt_new.max_ns;
                        cat_samples_next    = cat_new.cnt;
                        cat_total_next      = cat_new.sum_ns;
                    end
                    else
                    begin
                        if (bkt_ok)
                        begin
                            bucket_samples_next = bkt_rd.cnt;
                            bucket_min_next     = bkt_rd.min_ns;
                            bucket_max_next     = bkt_rd.max_ns;
                        end
                        cat_samples_next = cat_rd.cnt;
                        cat_total_next   = cat_rd.sum_ns;
                    end
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clr_reg            <= '0;
            op_reg             <= OP_RECORD;
            cat_reg            <= '0;
            dur_reg            <= '0;
            bucket_reg         <= '0;
            thr_reg            <= '0;
            done_reg           <= 1'b0;
            bucket_index_reg   <= '0;
            bucket_samples_reg <= '0;
            bucket_min_reg     <= '0;
            bucket_max_reg     <= '0;
            cat_samples_reg    <= '0;
            cat_total_reg      <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            clr_reg            <= clr_next;
            op_reg             <= op_next;
            cat_reg            <= cat_next;
            dur_reg            <= dur_next;
            bucket_reg         <= bucket_next;
            thr_reg            <= thr_next;
            done_reg           <= done_next;
            bucket_index_reg   <= bucket_index_next;
            bucket_samples_reg <= bucket_samples_next;
            bucket_min_reg     <= bucket_min_next;
            bucket_max_reg     <= bucket_max_next;
            cat_samples_reg    <= cat_samples_next;
            cat_total_reg      <= cat_total_next;
        end
    end

    assign busy              = (state_reg != ST_IDLE);
    assign done              = done_reg;
    assign bucket_index      = bucket_index_reg;
    assign bucket_samples    = bucket_samples_reg;
    assign bucket_min_ns     = bucket_min_reg;
    assign bucket_max_ns     = bucket_max_reg;
    assign category_samples  = cat_samples_reg;
    assign category_total_ns = cat_total_reg;

endmodule

`default_nettype wire

/* hdl/lbdh_checker.sv */
// lbdh_checker: port-level assertions for the log bucket duration histogram,
// bound to the top level. Depends on lbdh_pkg.
`default_nettype none

module lbdh_checker
    import lbdh_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire logic [CNT_W-1:0] bucket_samples,
    input wire logic [DUR_W-1:0] bucket_min_ns,
    input wire logic [DUR_W-1:0] bucket_max_ns,
    input wire logic [CNT_W-1:0] category_samples,
    input wire logic [SUM_W-1:0] category_total_ns
);

    // an accepted item always occupies the block for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // a result is shown only once the block is free again
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // a result is shown in idle and another needs a new item to pass the update state, so strobes never touch
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobes back to back");

    // a bucket holding samples keeps its minimum at or below its maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (bucket_samples != '0)) |-> (bucket_min_ns <= bucket_max_ns))
        else $error("bucket minimum above maximum");

    // a category with no samples has no accumulated time
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (category_samples == '0)) |-> (category_total_ns == '0))
        else $error("category total without samples");

endmodule

bind log_bucket_duration_histogram lbdh_checker u_lbdh_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .bucket_samples    (bucket_samples),
    .bucket_min_ns     (bucket_min_ns),
    .bucket_max_ns     (bucket_max_ns),
    .category_samples  (category_samples),
    .category_total_ns (category_total_ns)
);

`default_nettype wire
